/* rtl/lomb_pkg.sv */
// Shared types and constants of the limit order matching book.
package lomb_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int MAX_RESULTS = 32;
  localparam int TRADE_W     = $clog2(MAX_RESULTS);
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 232;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NO_CROSS  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_ZERO_QTY  = 3'd6
  } status_e;

  typedef enum logic {
    MODE_ADD    = 1'b0,
    MODE_CANCEL = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_TRADE = 1'b0,
    KIND_DONE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_MATCH,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    mode_e              mode;
    logic [63:0]        order_id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        amount;
    logic               fak;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [63:0]        bid_id;
    logic signed [31:0] bid_price;
    logic [63:0]        ask_id;
    logic signed [31:0] ask_price;
    logic [31:0]        fill;
    logic               last;
  } result_t;

  // Queue handshake between the front and the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

/* rtl/lomb_front.sv */
// Front end: unpacks requests and holds them in a two-entry queue.
module lomb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [lomb_pkg::IN_TDATA_W-1:0] s_tdata_i,
  input  logic                           s_tuser_i,
  output lomb_pkg::queue_out_t           q_o,
  input  logic                           pop_i
);
  import lomb_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  item_t      in_item;
  logic       push;

  always_comb begin
    in_item.mode     = mode_e'(s_tuser_i);
    in_item.order_id = s_tdata_i[63:0];
    in_item.side     = s_tdata_i[64];
    in_item.price    = s_tdata_i[96:65];
    in_item.amount   = s_tdata_i[128:97];
    in_item.fak      = s_tdata_i[129];
  end

  assign s_tready_o = (cnt_q != 2'd2);
  assign push       = s_tvalid_i && s_tready_o;
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item;
  end

endmodule

/* rtl/lomb_back.sv */
// Back end: slot store, sequential best-price search and matching engine.
module lomb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lomb_pkg::queue_out_t q_i,
  output logic                 pop_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output lomb_pkg::result_t    res_o
);
  import lomb_pkg::*;

  logic               valid_q [ORDER_SLOTS];
  logic [63:0]        id_q    [ORDER_SLOTS];
  logic               side_q  [ORDER_SLOTS];
  logic signed [31:0] price_q [ORDER_SLOTS];
  logic [31:0]        rem_q   [ORDER_SLOTS];
  logic [63:0]        stamp_q [ORDER_SLOTS];
  logic [63:0]        arrival_q;

  fsm_e               state_q, state_d;
  item_t              cur_q;
  logic [SLOT_W-1:0]  idx_q;
  logic               rescan_q;
  logic               found_q, free_ok_q, bb_ok_q, ba_ok_q;
  logic [SLOT_W-1:0]  found_idx_q, free_idx_q, bb_idx_q, ba_idx_q, me_q;
  logic signed [31:0] bb_price_q, ba_price_q;
  logic [63:0]        bb_stamp_q, ba_stamp_q;
  logic [TRADE_W-1:0] ntr_q;
  logic               out_valid_q;
  result_t            out_q;

  logic               out_free, emit, scan_last;
  logic               bid_better, ask_better, cross_fak, reject, crossing, insert;
  result_t            res_d;
  logic [31:0]        qty;

  assign out_free  = !out_valid_q || m_tready_i;
  assign scan_last = (idx_q == SLOT_W'(ORDER_SLOTS - 1));

  // Price-time comparison of the scanned slot against the running best.
  assign bid_better = !bb_ok_q || (price_q[idx_q] > bb_price_q) ||
                      (price_q[idx_q] == bb_price_q && stamp_q[idx_q] < bb_stamp_q);
  assign ask_better = !ba_ok_q || (price_q[idx_q] < ba_price_q) ||
                      (price_q[idx_q] == ba_price_q && stamp_q[idx_q] < ba_stamp_q);

  assign cross_fak = cur_q.side ? (bb_ok_q && cur_q.price <= bb_price_q)
                                : (ba_ok_q && cur_q.price >= ba_price_q);
  assign crossing  = bb_ok_q && ba_ok_q && (bb_price_q >= ba_price_q) &&
                     (ntr_q < TRADE_W'(MAX_RESULTS - 1));
  assign qty       = (rem_q[bb_idx_q] < rem_q[ba_idx_q]) ? rem_q[bb_idx_q]
                                                         : rem_q[ba_idx_q];

  // Outputs of the sequencer.
  always_comb begin
    res_d        = '0;
    res_d.kind   = KIND_DONE;
    res_d.last   = 1'b1;
    res_d.status = ST_ADDED;
    emit         = 1'b0;
    reject       = 1'b0;
    insert       = 1'b0;
    pop_o        = (state_q == FSM_IDLE) && q_i.valid;
    case (state_q)
      FSM_DECIDE: begin
        if (cur_q.mode == MODE_CANCEL) begin
          emit         = out_free;
          res_d.status = found_q ? ST_CANCELLED : ST_UNKNOWN;
          res_d.fill   = found_q ? rem_q[found_idx_q] : 32'd0;
        end else begin
          reject = 1'b1;
          if (found_q) res_d.status = ST_DUPLICATE;
          else if (cur_q.amount == 32'd0) res_d.status = ST_ZERO_QTY;
          else if (cur_q.fak && !cross_fak) res_d.status = ST_NO_CROSS;
          else if (!free_ok_q) res_d.status = ST_FULL;
          else reject = 1'b0;
          emit   = reject && out_free;
          insert = !reject && out_free;
        end
      end
      FSM_MATCH: begin
        if (crossing) begin
          emit            = out_free;
          res_d.kind      = KIND_TRADE;
          res_d.last      = 1'b0;
          res_d.bid_id    = id_q[bb_idx_q];
          res_d.bid_price = price_q[bb_idx_q];
          res_d.ask_id    = id_q[ba_idx_q];
          res_d.ask_price = price_q[ba_idx_q];
          res_d.fill      = qty;
        end
      end
      FSM_DONE: begin
        emit       = out_free;
        res_d.fill = valid_q[me_q] ? rem_q[me_q] : 32'd0;
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:   if (q_i.valid) state_d = FSM_SCAN;
      FSM_SCAN:   if (scan_last) state_d = rescan_q ? FSM_MATCH : FSM_DECIDE;
      FSM_DECIDE: begin
        if (emit) state_d = FSM_IDLE;
        else if (insert) state_d = FSM_MATCH;
      end
      FSM_MATCH: begin
        if (!crossing) state_d = FSM_DONE;
        else if (emit) state_d = FSM_SCAN;
      end
      FSM_DONE:   if (emit) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      arrival_q   <= '0;
      out_valid_q <= 1'b0;
      rescan_q    <= 1'b0;
      found_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      bb_ok_q     <= 1'b0;
      ba_ok_q     <= 1'b0;
      idx_q       <= '0;
      ntr_q       <= '0;
      for (int i = 0; i < ORDER_SLOTS; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
      case (state_q)
        FSM_IDLE: begin
          if (q_i.valid) begin
            rescan_q  <= 1'b0;
            found_q   <= 1'b0;
            free_ok_q <= 1'b0;
            bb_ok_q   <= 1'b0;
            ba_ok_q   <= 1'b0;
            idx_q     <= '0;
          end
        end
        FSM_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (valid_q[idx_q]) begin
            if (!found_q && id_q[idx_q] == cur_q.order_id) begin
              found_q     <= 1'b1;
              found_idx_q <= idx_q;
            end
            if (!side_q[idx_q] && bid_better) begin
              bb_ok_q    <= 1'b1;
              bb_idx_q   <= idx_q;
              bb_price_q <= price_q[idx_q];
              bb_stamp_q <= stamp_q[idx_q];
            end
            if (side_q[idx_q] && ask_better) begin
              ba_ok_q    <= 1'b1;
              ba_idx_q   <= idx_q;
              ba_price_q <= price_q[idx_q];
              ba_stamp_q <= stamp_q[idx_q];
            end
          end else if (!free_ok_q) begin
            free_ok_q  <= 1'b1;
            free_idx_q <= idx_q;
          end
        end
        FSM_DECIDE: begin
          if (emit && cur_q.mode == MODE_CANCEL && found_q)
            valid_q[found_idx_q] <= 1'b0;
          if (insert) begin
            valid_q[free_idx_q] <= 1'b1;
            me_q      <= free_idx_q;
            arrival_q <= arrival_q + 64'd1;
            ntr_q     <= '0;
            // The new order is the youngest, so it leads its side only on a strictly
            // better price.
            if (!cur_q.side && (!bb_ok_q || cur_q.price > bb_price_q)) begin
              bb_ok_q    <= 1'b1;
              bb_idx_q   <= free_idx_q;
              bb_price_q <= cur_q.price;
              bb_stamp_q <= arrival_q;
            end
            if (cur_q.side && (!ba_ok_q || cur_q.price < ba_price_q)) begin
              ba_ok_q    <= 1'b1;
              ba_idx_q   <= free_idx_q;
              ba_price_q <= cur_q.price;
              ba_stamp_q <= arrival_q;
            end
          end
        end
        FSM_MATCH: begin
          if (crossing && emit) begin
            if (rem_q[bb_idx_q] == qty) valid_q[bb_idx_q] <= 1'b0;
            if (rem_q[ba_idx_q] == qty) valid_q[ba_idx_q] <= 1'b0;
            ntr_q    <= ntr_q + 1'b1;
            rescan_q <= 1'b1;
            bb_ok_q  <= 1'b0;
            ba_ok_q  <= 1'b0;
            idx_q    <= '0;
          end
        end
        FSM_DONE: begin
          if (emit && cur_q.fak) valid_q[me_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_i.item;
    if (emit) out_q <= res_d;
    if (insert) begin
      id_q[free_idx_q]    <= cur_q.order_id;
      side_q[free_idx_q]  <= cur_q.side;
      price_q[free_idx_q] <= cur_q.price;
      rem_q[free_idx_q]   <= cur_q.amount;
      stamp_q[free_idx_q] <= arrival_q;
    end
    if (state_q == FSM_MATCH && crossing && emit) begin
      rem_q[bb_idx_q] <= rem_q[bb_idx_q] - qty;
      rem_q[ba_idx_q] <= rem_q[ba_idx_q] - qty;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign res_o      = out_q;

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result issued over a waiting result");
  a_trade_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ntr_q <= TRADE_W'(MAX_RESULTS - 1)) else $error("trade count overrun");
  a_trade_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_MATCH && crossing) |-> (valid_q[bb_idx_q] && valid_q[ba_idx_q]))
    else $error("trade against an empty slot");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == FSM_SCAN)) else $error("pop without a scan");

endmodule

/* rtl/limit_order_matching_book.sv */
// Top level of the price-time priority limit order matching book.
// Requests arrive on the s_axis channel: tuser is the mode (add or cancel by
// id), tdata carries the order id, side, limit price, amount and fill-and-kill
// flag. Results leave on the m_axis channel: tuser is the kind (trade or
// completion) and tlast marks the completion that closes each request.
// A two-entry queue takes requests while the matching engine is busy.
// Every request costs one pass over the ORDER_SLOTS slots (one slot a cycle),
// and each trade of an add costs a further pass over the slots. The engine
// takes the next request from the queue only once the closing result of the
// current one has been issued.
// Results go through one output register; when the receiver holds tready low
// the engine waits with the next result and the queue keeps filling.
// Reset empties the book and the queue and zeroes the arrival counter; no
// clearing pass is needed.
module limit_order_matching_book (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // order_id[63:0], side[64], limit_price[96:65], amount[128:97],
  // fill_and_kill[129], zero pad
  input  logic [lomb_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status[2:0], bid_order_id[66:3], bid_price[98:67], ask_order_id[162:99],
  // ask_price[194:163], fill_amount[226:195], zero pad
  output logic [lomb_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // kind
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import lomb_pkg::*;

  queue_out_t q;
  logic       pop;
  result_t    res;

  lomb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .q_o        (q),
    .pop_i      (pop)
  );

  lomb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_i        (q),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {5'd0, res.fill, res.ask_price, res.ask_id,
                           res.bid_price, res.bid_id, res.status};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule
